>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL top level.
// No dependencies; ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/sgbm_pkg.sv
// Package for the background model: widths, constants, entry and control types.
// No dependencies.
package sgbm_pkg;
  localparam int unsigned MAX_PIXELS = 131072;
  localparam int unsigned NCH        = 3;
  localparam int unsigned PIX_AW     = $clog2(MAX_PIXELS);
  localparam int unsigned ADDR_W     = 17;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned MEAN_W     = 16;
  localparam int unsigned VARI_W     = 24;
  localparam logic [ALPHA_W-1:0] ONE_Q16       = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 17'd655;
  localparam logic [VARI_W-1:0]  INIT_VARIANCE = 24'd2560000;

  typedef enum logic [1:0] {
    REG_ALPHA     = 2'd0,
    REG_COLOUR    = 2'd1,
    REG_SELECTIVE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_INIT     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [VARI_W-1:0] variance;
    logic [MEAN_W-1:0] mean;
  } entry_t;

  typedef entry_t [NCH-1:0] row_t;

  typedef struct packed {
    logic               adv;
    logic [ALPHA_W-1:0] a;
    logic [ALPHA_W-1:0] om;
  } chan_ctl_t;
endpackage

>>> rtl/core/sgbm_in_if.sv
// Input channel: valid/ready handshake carrying one pixel item.
// Depends on nothing.
interface sgbm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [16:0] pixel_index;
  logic [7:0]  chan_zero;
  logic [7:0]  chan_one;
  logic [7:0]  chan_two;
  modport source (output valid, command, pixel_index, chan_zero, chan_one, chan_two,
                  input ready);
  modport sink   (input valid, command, pixel_index, chan_zero, chan_one, chan_two,
                  output ready);
endinterface

>>> rtl/core/sgbm_out_if.sv
// Output channel: valid/ready handshake carrying one classification result.
// Depends on nothing.
interface sgbm_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] pixel_addr_out;
  logic        foreground;
  modport source (output valid, pixel_addr_out, foreground, input ready);
  modport sink   (input valid, pixel_addr_out, foreground, output ready);
endinterface

>>> rtl/core/sgbm_store.sv
// Model store: one row per pixel holding mean and variance of every channel.
// Depends on sgbm_pkg.
module sgbm_store (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [sgbm_pkg::PIX_AW-1:0] rd_idx_i,
  output sgbm_pkg::row_t              rd_row_o,
  input  logic                        wr_en_i,
  input  logic [sgbm_pkg::PIX_AW-1:0] wr_idx_i,
  input  sgbm_pkg::row_t              wr_row_i
);
  sgbm_pkg::row_t mem [sgbm_pkg::MAX_PIXELS];
  sgbm_pkg::row_t rd_row_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem[rd_idx_i];
    end
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_row_i;
    end
  end

  assign rd_row_o = rd_row_q;
endmodule

>>> rtl/core/sgbm_chan.sv
// Per-channel arithmetic pipeline: deviation, products, square, blend and compare.
// Depends on sgbm_pkg; three register stages after the store read.
module sgbm_chan (
  input  logic                        clk_i,
  input  sgbm_pkg::chan_ctl_t         ctl_i,
  input  logic [7:0]                  pix_i,
  input  sgbm_pkg::entry_t            ent_i,
  output logic [7:0]                  pix_o,
  output sgbm_pkg::entry_t            old_o,
  output sgbm_pkg::entry_t            new_o,
  output logic                        fg_o
);
  // stage 2
  logic [15:0] dev_q;
  logic [32:0] pa_q, pm_q;
  logic [7:0]  pix2_q;
  sgbm_pkg::entry_t ent2_q;
  // stage 3
  logic [31:0] sq_q;
  logic [15:0] nm_q;
  logic [7:0]  pix3_q;
  sgbm_pkg::entry_t ent3_q;
  // stage 4
  logic [48:0] pv1_q;
  logic [40:0] pv2_q;
  logic        fg_q;
  logic [15:0] nm4_q;
  logic [7:0]  pix4_q;
  sgbm_pkg::entry_t ent4_q;

  logic [15:0] val;
  logic [15:0] dev;
  logic [33:0] nm_sum;
  logic [15:0] nm_sat;
  logic [31:0] sq;
  logic [49:0] nv_sum;
  logic [25:0] nv_raw;

  always_comb begin
    val    = {pix_i, 8'h00};
    dev    = (val >= ent_i.mean) ? (val - ent_i.mean) : (ent_i.mean - val);
    nm_sum = {1'b0, pa_q} + {1'b0, pm_q} + 34'd32768;
    nm_sat = (nm_sum[33:32] != 2'b00) ? 16'hFFFF : nm_sum[31:16];
    sq     = dev_q * dev_q;
    nv_sum = {1'b0, pv1_q} + {1'b0, pv2_q, 8'h00} + 50'd8388608;
    nv_raw = nv_sum[49:24];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      dev_q  <= dev;
      pa_q   <= ctl_i.a * {1'b0, val};
      pm_q   <= ctl_i.om * {1'b0, ent_i.mean};
      pix2_q <= pix_i;
      ent2_q <= ent_i;

      sq_q   <= sq;
      nm_q   <= nm_sat;
      pix3_q <= pix2_q;
      ent3_q <= ent2_q;

      pv1_q  <= ctl_i.a * sq_q;
      pv2_q  <= ctl_i.om * ent3_q.variance;
      fg_q   <= {2'b00, sq_q} > {ent3_q.variance, 10'h000};
      nm4_q  <= nm_q;
      pix4_q <= pix3_q;
      ent4_q <= ent3_q;
    end
  end

  assign pix_o           = pix4_q;
  assign old_o           = ent4_q;
  assign fg_o            = fg_q;
  assign new_o.mean      = nm4_q;
  assign new_o.variance  = (nv_raw[25:24] != 2'b00) ? 24'hFFFFFF : nv_raw[23:0];
endmodule

>>> rtl/core/single_gaussian_background_model.sv
// Single-Gaussian background model, top level: control pipeline, store, results.
// Depends on sgbm_pkg, sgbm_in_if, sgbm_out_if, sgbm_store, sgbm_chan, assert_macros.svh.
//
// Keeps a running Gaussian (mean 8.8, variance 16.8) per pixel and channel in
// an on-chip row store of MAX_PIXELS rows. An init item loads mean = pixel and
// variance = 100^2 and produces no transfer on the output; a classify item
// produces one transfer, foreground when any active channel has
// (val-mean)^2 > 4*variance, and blends the model with alpha (rounded to
// nearest), for background pixels only when selective update is on.
// Throughput is one item per clock unless a hazard or the output holds it off. The
// store read is registered at the input transfer edge, then deviation/products,
// square/mean blend and variance products/compare take one stage each, and then
// the output register is loaded, where the row is written back. An item whose
// pixel is still in those four stages is held off (ready low) until that pixel's
// write-back lands, so back-to-back hits on the same pixel stall the input. The
// whole pipeline stalls while a result waits on the output. The store is not
// cleared: a pixel must be initialized before it is classified. Configuration
// must be written only while the block is empty; the block itself does not
// enforce this.
`include "assert_macros.svh"
module single_gaussian_background_model (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [sgbm_pkg::CFG_W-1:0]   cfg_data_i,
  sgbm_in_if.sink                      in_i,
  sgbm_out_if.source                   out_o
);
  localparam int unsigned NST = 4;

  // config registers
  logic [sgbm_pkg::ALPHA_W-1:0] alpha_q;
  logic                         colour_q;
  logic                         select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= sgbm_pkg::ALPHA_RST;
      colour_q <= 1'b1;
      select_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (sgbm_pkg::cfg_reg_e'(cfg_idx_i))
        sgbm_pkg::REG_ALPHA:     alpha_q  <= cfg_data_i[sgbm_pkg::ALPHA_W-1:0];
        sgbm_pkg::REG_COLOUR:    colour_q <= cfg_data_i[0];
        sgbm_pkg::REG_SELECTIVE: select_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturate alpha above one
  sgbm_pkg::chan_ctl_t ctl;
  logic adv;
  logic out_valid_q;

  assign adv    = !out_valid_q || out_o.ready;
  assign ctl.adv = adv;
  assign ctl.a  = (alpha_q > sgbm_pkg::ONE_Q16) ? sgbm_pkg::ONE_Q16 : alpha_q;
  assign ctl.om = sgbm_pkg::ONE_Q16 - ctl.a;

  // control pipeline, stage 1..4
  logic [NST-1:0]              v_q;
  logic [NST-1:0]              cmd_q;
  logic [sgbm_pkg::ADDR_W-1:0] addr_q [NST];
  logic [7:0]                  pix1_q [sgbm_pkg::NCH];

  logic [sgbm_pkg::PIX_AW-1:0] in_idx;
  logic [sgbm_pkg::PIX_AW-1:0] stg_row [NST];
  logic                        hazard;
  logic                        in_xfer;

  assign in_idx = in_i.pixel_index[sgbm_pkg::PIX_AW-1:0];

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NST; k++) begin
      stg_row[k] = addr_q[k][sgbm_pkg::PIX_AW-1:0];
      if (v_q[k] && (stg_row[k] == in_idx)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_i.ready = adv && !hazard;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_xfer};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q     <= {cmd_q[NST-2:0], in_i.command};
      addr_q[0] <= in_i.pixel_index;
      for (int k = 1; k < NST; k++) begin
        addr_q[k] <= addr_q[k-1];
      end
      pix1_q[0] <= in_i.chan_zero;
      if (sgbm_pkg::NCH > 1) pix1_q[1 % sgbm_pkg::NCH] <= in_i.chan_one;
      if (sgbm_pkg::NCH > 2) pix1_q[2 % sgbm_pkg::NCH] <= in_i.chan_two;
    end
  end

  // store
  sgbm_pkg::row_t rd_row, wr_row;
  logic           wr_en;

  sgbm_store u_store (
    .clk_i    (clk_i),
    .rd_en_i  (adv),
    .rd_idx_i (in_idx),
    .rd_row_o (rd_row),
    .wr_en_i  (wr_en),
    .wr_idx_i (addr_q[NST-1][sgbm_pkg::PIX_AW-1:0]),
    .wr_row_i (wr_row)
  );

  // channel datapaths
  logic [7:0]          pix4   [sgbm_pkg::NCH];
  sgbm_pkg::entry_t    old_e  [sgbm_pkg::NCH];
  sgbm_pkg::entry_t    new_e  [sgbm_pkg::NCH];
  logic [sgbm_pkg::NCH-1:0] fg_ch;

  for (genvar c = 0; c < sgbm_pkg::NCH; c++) begin : g_chan
    sgbm_chan u_chan (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .pix_i (pix1_q[c]),
      .ent_i (rd_row[c]),
      .pix_o (pix4[c]),
      .old_o (old_e[c]),
      .new_o (new_e[c]),
      .fg_o  (fg_ch[c])
    );
  end

  // stage 4: decision and write-back row
  logic [sgbm_pkg::NCH-1:0] act;
  logic                     fg;
  logic                     upd;
  logic                     cmd4;

  assign cmd4 = cmd_q[NST-1];

  always_comb begin
    for (int c = 0; c < sgbm_pkg::NCH; c++) begin
      act[c] = (c == 0) || colour_q;
    end
    fg  = |(fg_ch & act);
    upd = (cmd4 == sgbm_pkg::CMD_CLASSIFY) && (!select_q || !fg);
    for (int c = 0; c < sgbm_pkg::NCH; c++) begin
      if (!act[c]) begin
        wr_row[c] = old_e[c];
      end else if (cmd4 == sgbm_pkg::CMD_INIT) begin
        wr_row[c].mean     = {pix4[c], 8'h00};
        wr_row[c].variance = sgbm_pkg::INIT_VARIANCE;
      end else if (upd) begin
        wr_row[c] = new_e[c];
      end else begin
        wr_row[c] = old_e[c];
      end
    end
  end

  assign wr_en = adv && v_q[NST-1];

  // output register
  logic [sgbm_pkg::ADDR_W-1:0] out_addr_q;
  logic                        out_fg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_q[NST-1] && (cmd4 == sgbm_pkg::CMD_CLASSIFY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_addr_q <= addr_q[NST-1];
      out_fg_q   <= fg;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pixel_addr_out = out_addr_q;
  assign out_o.foreground     = out_fg_q;

  // items in stage pairs 1/2, 1/4 and 2/3 never share a pixel row
  `ASSERT_ALWAYS(a_row_12, clk_i, rst_ni, !(v_q[0] && v_q[1]) || (stg_row[0] != stg_row[1]))
  `ASSERT_ALWAYS(a_row_14, clk_i, rst_ni, !(v_q[0] && v_q[3]) || (stg_row[0] != stg_row[3]))
  `ASSERT_ALWAYS(a_row_23, clk_i, rst_ni, !(v_q[1] && v_q[2]) || (stg_row[1] != stg_row[2]))
  // a classify item leaving the pipeline becomes a result
  `ASSERT_NEXT(a_result, clk_i, rst_ni, wr_en && (cmd4 == sgbm_pkg::CMD_CLASSIFY), out_valid_q)
  // a stalled pipeline writes nothing
  `ASSERT_ALWAYS(a_stall_wr, clk_i, rst_ni, adv || !wr_en)
endmodule

>>> test/sgbm_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side channel helpers: none are needed, this file holds no declarations.
// The testbench drives the RTL interfaces sgbm_in_if and sgbm_out_if directly.

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for single_gaussian_background_model.
// Depends on sgbm_pkg, sgbm_in_if and sgbm_out_if; predicts classify results.
module testbench;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        command;
    logic [16:0] pixel_index;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
  } pixel_item_t;

  typedef struct packed {
    logic [16:0] addr;
    logic        fg;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [sgbm_pkg::CFG_W-1:0] cfg_data_i = '0;

  sgbm_in_if  pix_if ();
  sgbm_out_if res_if ();

  single_gaussian_background_model dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(pix_if.sink), .out_o(res_if.source)
  );

  // predictor state: sparse model stores, written by init items and classify updates
  logic [15:0] mean_m [int];
  logic [23:0] var_m [int];
  logic [16:0] alpha_r = sgbm_pkg::ALPHA_RST;
  logic colour_r = 1'b1;
  logic selective_r = 1'b1;

  pixel_item_t pending[$];
  verdict_t    verdicts[$];
  logic        initd [int];   // pixels whose entries are valid in current mode
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;           // last part of the run: no idling
  int in_gap = 0, out_gap = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [63:0] sq_dev(logic [7:0] v, logic [15:0] m);
    logic [63:0] d;
    d = ({v, 8'h00} >= m) ? 64'({v, 8'h00} - m) : 64'(m - {v, 8'h00});
    return d * d;
  endfunction

  // apply one accepted item to the model; queue a verdict for classify
  task automatic model_pixel(pixel_item_t it);
    logic [7:0] px [3];
    int base, n;
    logic [63:0] a, d2, nm, nv;
    logic fg;
    px[0] = it.c0; px[1] = it.c1; px[2] = it.c2;
    base = int'(it.pixel_index) * int'(sgbm_pkg::NCH);
    n = colour_r ? 3 : 1;
    a = (alpha_r > sgbm_pkg::ONE_Q16) ? 64'(sgbm_pkg::ONE_Q16) : 64'(alpha_r);
    fg = 1'b0;
    if (it.command == sgbm_pkg::CMD_INIT) begin
      for (int c = 0; c < n; c++) begin
        mean_m[base+c] = {px[c], 8'h00};
        var_m[base+c] = sgbm_pkg::INIT_VARIANCE;
      end
      return;
    end
    for (int c = 0; c < n; c++)
      if (sq_dev(px[c], mean_m[base+c]) > ((64'(var_m[base+c]) << 8) * 64'd4)) fg = 1'b1;
    if (!selective_r || !fg) begin
      for (int c = 0; c < n; c++) begin
        d2 = sq_dev(px[c], mean_m[base+c]);
        nm = (a * (64'(px[c]) << 8) + (64'(sgbm_pkg::ONE_Q16) - a) * 64'(mean_m[base+c])
              + 64'd32768) >> 16;
        nv = (a * d2 + (64'(sgbm_pkg::ONE_Q16) - a) * (64'(var_m[base+c]) << 8)
              + (64'd1 << 23)) >> 24;
        if (nm > 64'hFFFF) nm = 64'hFFFF;
        if (nv > 64'hFFFFFF) nv = 64'hFFFFFF;
        mean_m[base+c] = nm[15:0];
        var_m[base+c] = nv[23:0];
      end
    end
    verdicts.push_back('{addr: it.pixel_index, fg: fg});
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.command <= 1'b0;
      pix_if.pixel_index <= '0;
      pix_if.chan_zero <= '0;
      pix_if.chan_one <= '0;
      pix_if.chan_two <= '0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        model_pixel(pending.pop_front());
      end
      if (!(pix_if.valid && !pix_if.ready)) begin
        if (in_gap > 0) in_gap--;
        else if (!quiet && $urandom_range(0, 15) == 0) in_gap = int'($urandom_range(1, 11));
        if (in_gap == 0 && pending.size() > 0) begin
          pix_if.valid <= 1'b1;
          pix_if.command <= pending[0].command;
          pix_if.pixel_index <= pending[0].pixel_index;
          pix_if.chan_zero <= pending[0].c0;
          pix_if.chan_one <= pending[0].c1;
          pix_if.chan_two <= pending[0].c2;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      cycles++;
      if (res_if.valid && res_if.ready) begin
        if (verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result addr=%0d fg=%0d", $time,
                   res_if.pixel_addr_out, res_if.foreground);
        end else begin
          verdict_t exp_v;
          exp_v = verdicts.pop_front();
          if (exp_v.addr !== res_if.pixel_addr_out) begin
            errors++;
            $display("%0t: addr expected %0d actual %0d", $time, exp_v.addr,
                     res_if.pixel_addr_out);
          end
          if (exp_v.fg !== res_if.foreground) begin
            errors++;
            $display("%0t: foreground expected %0d actual %0d (addr %0d)", $time,
                     exp_v.fg, res_if.foreground, exp_v.addr);
          end
        end
      end
      if (out_gap > 0) out_gap--;
      else if (!quiet && $urandom_range(0, 15) == 0) out_gap = int'($urandom_range(1, 11));
      res_if.ready <= (out_gap == 0);
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic cfg_write(sgbm_pkg::cfg_reg_e idx, logic [sgbm_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sgbm_pkg::REG_ALPHA:  alpha_r = val;
      sgbm_pkg::REG_COLOUR: colour_r = val[0];
      default:              selective_r = val[0];
    endcase
  endtask

  // wait until every item is taken and every result seen, then drain
  task automatic drain();
    while (pending.size() > 0 || pix_if.valid || verdicts.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic pixel_item_t mk(logic cmd, logic [16:0] p,
                                     logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return '{command: cmd, pixel_index: p, c0: a, c1: b, c2: c};
  endfunction

  // pool of pixels: small range to force same-pixel hazards, plus far ones
  function automatic logic [16:0] rand_pix();
    if ($urandom_range(0, 3) == 0) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 31));
  endfunction

  // random phase: init pixels, then mostly classify initialized ones
  task automatic random_phase(int count);
    logic [16:0] p;
    logic [7:0] b;
    initd.delete();
    for (int i = 0; i < count; i++) begin
      p = rand_pix();
      if (!initd.exists(int'(p)) || $urandom_range(0, 9) == 0) begin
        pending.push_back(mk(sgbm_pkg::CMD_INIT, p, 8'($urandom), 8'($urandom),
                             8'($urandom)));
        initd[int'(p)] = 1'b1;
      end else begin
        b = 8'($urandom);
        // mix near-background values and wild ones
        if ($urandom_range(0, 1) == 1)
          pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, p, 8'($urandom), 8'($urandom),
                               8'($urandom)));
        else
          pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, p, b, b + 8'($urandom_range(0, 3)),
                               b - 8'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, extremes of fields and values
    pending.push_back(mk(sgbm_pkg::CMD_INIT, 17'd0, 8'd0, 8'd255, 8'd128));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd0, 8'd0, 8'd255, 8'd128));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd0, 8'd255, 8'd0, 8'd128));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd0, 8'd0, 8'd255, 8'd128));
    pending.push_back(mk(sgbm_pkg::CMD_INIT, 17'h1FFFF, 8'd255, 8'd255, 8'd255));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'h1FFFF, 8'd255, 8'd255, 8'd55));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'h1FFFF, 8'd0, 8'd0, 8'd0));
    pending.push_back(mk(sgbm_pkg::CMD_INIT, 17'h15555, 8'h55, 8'hAA, 8'h0F));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'h15555, 8'hAA, 8'h55, 8'hF0));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'h15555, 8'h55, 8'hAA, 8'h0F));
    drain();

    // grey mode, non-selective, alpha above one, one and zero
    cfg_write(sgbm_pkg::REG_COLOUR, 17'd0);
    cfg_write(sgbm_pkg::REG_SELECTIVE, 17'd0);
    cfg_write(sgbm_pkg::REG_ALPHA, 17'h1FFFF);
    pending.push_back(mk(sgbm_pkg::CMD_INIT, 17'd5, 8'd10, 8'd0, 8'd0));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd250, 8'd1, 8'd2));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd250, 8'd3, 8'd4));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd0, 8'd3, 8'd4));
    drain();
    cfg_write(sgbm_pkg::REG_ALPHA, 17'h10000);
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd1, 8'd9, 8'd9));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd200, 8'd9, 8'd9));
    drain();
    cfg_write(sgbm_pkg::REG_ALPHA, 17'd0);
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd0, 8'd9, 8'd9));
    pending.push_back(mk(sgbm_pkg::CMD_CLASSIFY, 17'd5, 8'd255, 8'd9, 8'd9));
    drain();

    // random phases across settings; every phase re-inits its pixels
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(sgbm_pkg::REG_COLOUR, {16'd0, ph[0]});
      cfg_write(sgbm_pkg::REG_SELECTIVE, {16'd0, ph[1]});
      case (ph % 4)
        0: cfg_write(sgbm_pkg::REG_ALPHA, 17'($urandom_range(0, 4000)));
        1: cfg_write(sgbm_pkg::REG_ALPHA, 17'($urandom_range(0, 131071)));
        2: cfg_write(sgbm_pkg::REG_ALPHA, 17'($urandom_range(30000, 65536)));
        default: cfg_write(sgbm_pkg::REG_ALPHA, sgbm_pkg::ALPHA_RST);
      endcase
      if (ph == 7) quiet = 1'b1;
      random_phase(170);
      drain();
    end

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
